FILE: hdl/matrix4_column_transform_core_defines.svh
// assertion macros shared by the matrix transform rtl
`ifndef MATRIX4_COLUMN_TRANSFORM_CORE_DEFINES_SVH
`define MATRIX4_COLUMN_TRANSFORM_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define M4CT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define M4CT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/m4ct_pkg.sv
// types and constants of the 4x4 matrix column transform
package m4ct_pkg;

  localparam int unsigned NUM_ROWS   = 4;
  localparam int unsigned NUM_COLS   = 4;
  localparam int unsigned NUM_REGS   = 8;
  localparam int unsigned REG_W      = 64;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned REG_IDX_LSB = 3;
  localparam int unsigned CFG_ADDR_W = REG_IDX_W + REG_IDX_LSB;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned PROD_W     = 2 * DATA_W;
  localparam int unsigned PAIR_W     = PROD_W + 1;
  localparam int unsigned SUM_W      = PROD_W + 2;

  localparam logic [DATA_W-1:0] ONE_Q   = 32'h0001_0000;
  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef logic [NUM_REGS-1:0][REG_W-1:0] cfg_regs_t;

  // identity matrix, register 7 first
  localparam cfg_regs_t CFG_RESET = {
    64'h0001_0000_0000_0000, 64'h0,
    64'h0000_0000_0001_0000, 64'h0,
    64'h0,                   64'h0001_0000_0000_0000,
    64'h0,                   64'h0000_0000_0001_0000
  };

  typedef logic [NUM_ROWS-1:0][NUM_COLS-1:0][DATA_W-1:0] coef_mat_t;
  typedef logic [NUM_COLS-1:0][DATA_W-1:0]              vec_t;

  typedef struct packed {
    logic              affine_mode;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] in_w;
    logic              final_column;
  } m4ct_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic              clipped;
    logic              final_out;
  } m4ct_out_t;

  // per-row partial results travelling down the pipe
  typedef struct packed {
    logic [NUM_ROWS-1:0][NUM_COLS-1:0][PROD_W-1:0] prod;
    logic                                          affine;
    logic                                          final_column;
  } prod_stage_t;

  typedef struct packed {
    logic [NUM_ROWS-1:0][SUM_W-1:0] sum;
    logic                           affine;
    logic                           final_column;
  } sum_stage_t;

endpackage

FILE: hdl/m4ct_cfg.sv
// apb coefficient registers of the matrix transform
module m4ct_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [m4ct_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [m4ct_pkg::REG_W-1:0]           pwdata,
  output logic [m4ct_pkg::REG_W-1:0]           prdata,
  output logic                                 pready,
  output m4ct_pkg::coef_mat_t                  coef_o
);
  import m4ct_pkg::*;

  cfg_regs_t              cfg_q;
  logic [REG_IDX_W-1:0]   reg_idx;

  assign reg_idx = paddr[CFG_ADDR_W-1:REG_IDX_LSB];
  assign pready  = 1'b1;
  assign prdata  = cfg_q[reg_idx];

  // register write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (psel && penable && pwrite && pready) begin
      cfg_q[reg_idx] <= pwdata;
    end
  end

  // unpack two coefficients per register
  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
    for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
      assign coef_o[r][c] = cfg_q[r*2 + c/2][(c%2)*DATA_W +: DATA_W];
    end
  end

endmodule

FILE: hdl/m4ct_mul.sv
// input register and sixteen-product multiply stage
module m4ct_mul (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  m4ct_pkg::m4ct_in_t     in_data_i,
  input  m4ct_pkg::coef_mat_t    coef_i,
  output logic                   prod_valid_o,
  input  logic                   prod_ready_i,
  output m4ct_pkg::prod_stage_t  prod_o
);
  import m4ct_pkg::*;

  logic        a_valid_q;
  vec_t        vec_q;
  logic        aff_q;
  logic        fin_q;
  logic        a_en;
  logic        b_valid_q;
  prod_stage_t prod_q;
  logic        b_en;

  assign b_en       = !b_valid_q || prod_ready_i;
  assign a_en       = !a_valid_q || b_en;
  assign in_ready_o = a_en;

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_en) begin
        a_valid_q <= in_valid_i;
      end
      if (b_en) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  // capture vector, w forced to one in affine mode
  always_ff @(posedge clk_i) begin
    if (a_en && in_valid_i) begin
      vec_q[0] <= in_data_i.in_x;
      vec_q[1] <= in_data_i.in_y;
      vec_q[2] <= in_data_i.in_z;
      vec_q[3] <= in_data_i.affine_mode ? ONE_Q : in_data_i.in_w;
      aff_q    <= in_data_i.affine_mode;
      fin_q    <= in_data_i.final_column;
    end
  end

  // full-width signed products
  always_ff @(posedge clk_i) begin
    if (b_en && a_valid_q) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int c = 0; c < NUM_COLS; c++) begin
          prod_q.prod[r][c] <= $signed(coef_i[r][c]) * $signed(vec_q[c]);
        end
      end
      prod_q.affine       <= aff_q;
      prod_q.final_column <= fin_q;
    end
  end

  assign prod_valid_o = b_valid_q;
  assign prod_o       = prod_q;

endmodule

FILE: hdl/m4ct_add.sv
// two-level adder tree per row
module m4ct_add (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   prod_valid_i,
  output logic                   prod_ready_o,
  input  m4ct_pkg::prod_stage_t  prod_i,
  output logic                   sum_valid_o,
  input  logic                   sum_ready_i,
  output m4ct_pkg::sum_stage_t   sum_o
);
  import m4ct_pkg::*;

  logic                                  c_valid_q;
  logic [NUM_ROWS-1:0][1:0][PAIR_W-1:0]  pair_q;
  logic                                  aff_q;
  logic                                  fin_q;
  logic                                  c_en;
  logic                                  d_valid_q;
  sum_stage_t                            sum_q;
  logic                                  d_en;

  assign d_en         = !d_valid_q || sum_ready_i;
  assign c_en         = !c_valid_q || d_en;
  assign prod_ready_o = c_en;

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      if (c_en) begin
        c_valid_q <= prod_valid_i;
      end
      if (d_en) begin
        d_valid_q <= c_valid_q;
      end
    end
  end

  // pairwise sums of products
  always_ff @(posedge clk_i) begin
    if (c_en && prod_valid_i) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int h = 0; h < 2; h++) begin
          pair_q[r][h] <= PAIR_W'($signed(prod_i.prod[r][2*h]))
                        + PAIR_W'($signed(prod_i.prod[r][2*h+1]));
        end
      end
      aff_q <= prod_i.affine;
      fin_q <= prod_i.final_column;
    end
  end

  // row totals
  always_ff @(posedge clk_i) begin
    if (d_en && c_valid_q) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        sum_q.sum[r] <= SUM_W'($signed(pair_q[r][0])) + SUM_W'($signed(pair_q[r][1]));
      end
      sum_q.affine       <= aff_q;
      sum_q.final_column <= fin_q;
    end
  end

  assign sum_valid_o = d_valid_q;
  assign sum_o       = sum_q;

endmodule

FILE: hdl/m4ct_sat.sv
// shift, saturate and output register
module m4ct_sat (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  sum_valid_i,
  output logic                  sum_ready_o,
  input  m4ct_pkg::sum_stage_t  sum_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output m4ct_pkg::m4ct_out_t   out_o
);
  import m4ct_pkg::*;

  localparam int unsigned TOP_LSB = DATA_W + FRAC_BITS - 1;

  logic [NUM_ROWS-1:0][DATA_W-1:0] row_val;
  logic [NUM_ROWS-1:0]             row_clip;
  logic [SUM_W-1:TOP_LSB]          top_bits;
  logic                            e_en;
  logic                            out_valid_q;
  m4ct_out_t                       out_q;
  m4ct_out_t                       out_d;

  // per-row range check and clamp
  always_comb begin
    row_val  = '0;
    row_clip = '0;
    top_bits = '0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      top_bits = sum_i.sum[r][SUM_W-1:TOP_LSB];
      if ((&top_bits) || !(|top_bits)) begin
        row_val[r] = sum_i.sum[r][FRAC_BITS +: DATA_W];
      end else begin
        row_clip[r] = 1'b1;
        row_val[r]  = sum_i.sum[r][SUM_W-1] ? SAT_MIN : SAT_MAX;
      end
    end
    // row 3 is not produced in affine mode
    if (sum_i.affine) begin
      row_val[3]  = '0;
      row_clip[3] = 1'b0;
    end
    out_d.out_x     = row_val[0];
    out_d.out_y     = row_val[1];
    out_d.out_z     = row_val[2];
    out_d.out_w     = row_val[3];
    out_d.clipped   = |row_clip;
    out_d.final_out = sum_i.final_column;
  end

  assign e_en        = !out_valid_q || out_ready_i;
  assign sum_ready_o = e_en;

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (e_en) begin
      out_valid_q <= sum_valid_i;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (e_en && sum_valid_i) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: hdl/matrix4_column_transform_core.sv
// top level of the streaming 4x4 matrix times column vector transform
//
// in channel: one request per column vector (x, y, z, w in signed q16.16,
// plus affine mode and a final-column mark), valid/ready handshake.
// out channel: one request per input request, in order, with the four
// saturated q16.16 rows, a clipped flag and the copied final mark.
// apb port: eight 64-bit coefficient registers at byte address 8*i,
// two q16.16 coefficients each; write them only while the pipe is empty.
// path: from input handshake to out_valid_o a request passes the input
// register (loaded at the handshake), 32x32 multiply, two adder levels, saturate.
// throughput: one vector per cycle unless the output stalls; the sixteen
// multipliers are fully pipelined and each stage holds one request.
// stall: when out_ready_i is low the pipe fills up stage by stage and
// in_ready_o drops only once every stage holds a request; nothing is lost.
// reset: all stages empty, coefficients load the identity matrix.
`include "matrix4_column_transform_core_defines.svh"

module matrix4_column_transform_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  m4ct_pkg::m4ct_in_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output m4ct_pkg::m4ct_out_t               out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [m4ct_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [m4ct_pkg::REG_W-1:0]        pwdata,
  output logic [m4ct_pkg::REG_W-1:0]        prdata,
  output logic                              pready
);
  import m4ct_pkg::*;

  coef_mat_t   coef;
  logic        prod_valid;
  logic        prod_ready;
  prod_stage_t prod;
  logic        sum_valid;
  logic        sum_ready;
  sum_stage_t  sum;

  // coefficient registers
  m4ct_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef_o  (coef)
  );

  // input register and products
  m4ct_mul u_mul (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .coef_i       (coef),
    .prod_valid_o (prod_valid),
    .prod_ready_i (prod_ready),
    .prod_o       (prod)
  );

  // adder tree
  m4ct_add u_add (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .prod_valid_i (prod_valid),
    .prod_ready_o (prod_ready),
    .prod_i       (prod),
    .sum_valid_o  (sum_valid),
    .sum_ready_i  (sum_ready),
    .sum_o        (sum)
  );

  // saturation and output register
  m4ct_sat u_sat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sum_valid_i (sum_valid),
    .sum_ready_o (sum_ready),
    .sum_i       (sum),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_data_o)
  );

  // back-pressure at the input only comes from a stalled full output
  `M4CT_ASSERT_IMP(a_stall_source, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i, "input stalled without output stall")

  // an empty output register means every stage can move
  `M4CT_ASSERT_IMP(a_empty_ready, clk_i, rst_ni, !out_valid_o, in_ready_o, "input not ready with empty output")

  // a clipped result carries at least one clamped row
  `M4CT_ASSERT_IMP(a_clip_value, clk_i, rst_ni, out_valid_o && out_data_o.clipped, (out_data_o.out_x == SAT_MAX) || (out_data_o.out_x == SAT_MIN) || (out_data_o.out_y == SAT_MAX) || (out_data_o.out_y == SAT_MIN) || (out_data_o.out_z == SAT_MAX) || (out_data_o.out_z == SAT_MIN) || (out_data_o.out_w == SAT_MAX) || (out_data_o.out_w == SAT_MIN), "clipped without saturated row")

  // a write to register zero lands in the row 0 column 0 coefficient
  `M4CT_ASSERT_NXT(a_cfg_write, clk_i, rst_ni, psel && penable && pwrite && (paddr == '0), coef[0][0] == $past(pwdata[DATA_W-1:0]), "coefficient write lost")

endmodule
